[rtl/signed_int_to_decimal_ascii_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to decimal ASCII unit
// Shared concurrent assertion forms, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

// Checked only while reset is released.
`define SITDA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SITDA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/sitda_pkg.sv]
// ----------------------------------------------------------------------------
// sitda_pkg
// Types and constants shared by the controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sitda_pkg;

    localparam int unsigned ValueW     = 32;
    localparam int unsigned CharW      = 8;
    localparam int unsigned NumDigits  = 10;
    localparam int unsigned CntW       = 4;
    localparam int unsigned DigitW     = 4;
    localparam int unsigned RecipShift = 35;

    localparam logic [CharW-1:0]  ChZero  = 8'h30;
    localparam logic [CharW-1:0]  ChMinus = 8'h2D;
    localparam logic [ValueW-1:0] Recip   = 32'hCCCC_CCCD;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic pop;
        logic sel_sign;
    } t_dp_cmd;

    typedef struct packed {
        logic neg;
        logic div_done;
        logic last_digit;
    } t_dp_stat;

endpackage

`default_nettype wire

[rtl/sitda_dp.sv]
// ----------------------------------------------------------------------------
// sitda_dp
// Magnitude, divide-by-ten step, digit store and character output.
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [sitda_pkg::ValueW-1:0]  i_value,
    input  sitda_pkg::t_dp_cmd                 i_cmd,
    output sitda_pkg::t_dp_stat                o_stat,
    output logic [sitda_pkg::CharW-1:0]        o_char,
    output logic                               o_last
);
    import sitda_pkg::*;

    localparam int unsigned QuotW = 2 * ValueW - RecipShift;

    logic                 r_neg;
    logic [ValueW-1:0]    r_mag;
    logic [2*ValueW-1:0]  r_prod;
    logic [DigitW-1:0]    r_digits [NumDigits];
    logic [CntW-1:0]      r_cnt;

    logic [2*ValueW-1:0]  prod_full;
    logic [ValueW-1:0]    quot;
    logic [ValueW-1:0]    quot_x10;
    logic [ValueW-1:0]    rem_full;
    logic [CntW-1:0]      rd_idx;
    logic [DigitW-1:0]    rd_digit;

    // Quotient by ten through the reciprocal; exact for every 32-bit value.
    assign prod_full = r_mag * Recip;
    assign quot      = ValueW'(r_prod[2*ValueW-1 -: QuotW]);
    assign quot_x10  = {quot[ValueW-4:0], 3'b000} + {quot[ValueW-2:0], 1'b0};
    assign rem_full  = r_mag - quot_x10;

    assign rd_idx   = r_cnt - 1'b1;
    assign rd_digit = (rd_idx < CntW'(NumDigits)) ? r_digits[rd_idx] : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_value[ValueW-1];
            r_mag <= i_value[ValueW-1] ? (ValueW'(0) - i_value) : i_value;
        end else if (i_cmd.div) begin
            r_mag            <= quot;
            r_digits[r_cnt]  <= rem_full[DigitW-1:0];
        end
        if (i_cmd.mul) begin
            r_prod <= prod_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.div) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.pop) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_stat.neg        = r_neg;
    assign o_stat.div_done   = (quot == '0) || (r_cnt == CntW'(NumDigits - 1));
    assign o_stat.last_digit = (r_cnt == CntW'(1));

    assign o_char = i_cmd.sel_sign ? ChMinus : (ChZero + CharW'(rd_digit));
    assign o_last = !i_cmd.sel_sign && o_stat.last_digit;

endmodule

`default_nettype wire

[rtl/sitda_ctrl.sv]
// ----------------------------------------------------------------------------
// sitda_ctrl
// Sequencer for conversion and character output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_int_to_decimal_ascii_unit_defines.svh"

module sitda_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  sitda_pkg::t_dp_stat i_stat,
    output sitda_pkg::t_dp_cmd  o_cmd
);
    import sitda_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (!i_stat.div_done) begin
                    n_state = ST_MUL;
                end else if (i_stat.neg) begin
                    n_state = ST_SIGN;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_SIGN: begin
                o_out_valid    = 1'b1;
                o_cmd.sel_sign = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.pop = 1'b1;
                    if (i_stat.last_digit) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `SITDA_ASSERT(a_no_overlap, o_in_ready |-> !o_out_valid, "input taken during output")
    `SITDA_ASSERT(a_accept_starts, (i_in_valid && o_in_ready) |=> (r_state == ST_MUL),
        "accepted value did not start conversion")
    `SITDA_ASSERT(a_last_ends, (r_state == ST_EMIT && i_out_ready && i_stat.last_digit)
        |=> o_in_ready, "final character did not return to idle")
    `SITDA_ASSERT(a_div_follows_mul, (r_state == ST_MUL) |=> (r_state == ST_DIV),
        "product not followed by divide step")

endmodule

`default_nettype wire

[rtl/signed_int_to_decimal_ascii_unit.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Converts a signed 32-bit integer into its decimal ASCII text, one
// character per output beat, most significant first.
// ----------------------------------------------------------------------------
// Sequence: each decimal digit takes a multiply step, which registers the
// product, and then a divide step, which updates the magnitude and stores
// the digit. The first character is offered once the final divide step is
// done. A new value is accepted only in idle, once the final character has
// been taken; the longest conversion is for -2147483648.
// Reset: synchronous active-low; returns the sequencer to idle.
`default_nettype none

module signed_int_to_decimal_ascii_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [sitda_pkg::ValueW-1:0]  i_s_axis_tdata,  // [31:0] value
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [sitda_pkg::CharW-1:0]        o_m_axis_tdata,  // [7:0] char_code
    output logic                               o_m_axis_tlast   // is_last
);
    import sitda_pkg::*;

    // The controller steps through load, the per-digit multiply and divide
    // pair, an optional minus sign and then the digit characters in reverse
    // order of extraction. The datapath holds the magnitude and digits; the
    // two talk only through the command and status structs.
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    sitda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // All output characters come straight from registered state: the sign
    // state of the controller and the digit store, selected by the remaining digit count.
    sitda_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_value (i_s_axis_tdata),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat),
        .o_char  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule

`default_nettype wire
